[rtl/gardner_timing_interpolator_defines.svh]
// Assertion helpers shared by the timing interpolator RTL.
`ifndef GARDNER_TIMING_INTERPOLATOR_DEFINES_SVH
`define GARDNER_TIMING_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTH
`define GTI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gti: implication check failed");
`define GTI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gti: next-cycle check failed");
`else
`define GTI_ASSERT_IMP(lbl, ante, cons)
`define GTI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/gti_pkg.sv]
`timescale 1ns / 1ps
package gti_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int PHASE_BITS  = 20;
	localparam int GAIN_BITS   = 22;
	localparam int SPS_BITS    = 8;
	localparam int ERR_BITS    = 32;
	localparam int CORR_SHIFT  = 15;
	localparam int MAX_SPS     = 12;
	localparam int SPS_RESET   = 10;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_BITS = 2;
	localparam logic [PHASE_BITS-1:0] NOM_RESET = PHASE_BITS'((1 << PHASE_BITS) / SPS_RESET);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ENABLE = 2'd0,
		CFG_SPS    = 2'd1,
		CFG_FORCE  = 2'd2,
		CFG_GAIN   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic                        enable;
		logic [SPS_BITS-1:0]         sps;
		logic                        force_high_rate;
		logic signed [GAIN_BITS-1:0] gain;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_PASS = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_STEP = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                     kind;
		logic signed [SAMPLE_BITS-1:0] x_i;
		logic signed [SAMPLE_BITS-1:0] x_q;
		logic                          last;
		logic                          pre;
	} cmd_t;
endpackage

[rtl/gti_if.sv]
`timescale 1ns / 1ps
interface gti_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [gti_pkg::SAMPLE_BITS-1:0] sample_i;
	logic signed [gti_pkg::SAMPLE_BITS-1:0] sample_q;
	logic                                   first_of_buffer;
	logic                                   last_of_buffer;

	modport source (output valid, output sample_i, output sample_q,
		output first_of_buffer, output last_of_buffer, input ready);
	modport sink (input valid, input sample_i, input sample_q,
		input first_of_buffer, input last_of_buffer, output ready);
endinterface

interface gti_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [gti_pkg::SAMPLE_BITS-1:0] out_i;
	logic signed [gti_pkg::SAMPLE_BITS-1:0] out_q;
	logic                                   out_last;

	modport source (output valid, output out_i, output out_q, output out_last, input ready);
	modport sink (input valid, input out_i, input out_q, input out_last, output ready);
endinterface

[rtl/gardner_timing_interpolator.sv]
`timescale 1ns / 1ps
// Gardner symbol timing interpolator for buffered complex I/Q samples.
// samples: valid/ready request channel, one complex sample per request with
//   first/last buffer marks. results: valid/ready channel of interpolated
//   values; out_last marks the final result of a buffer.
// cfg: write enable, register index (0 enable, 1 sps, 2 force, 3 gain), data.
// A front end classifies each request (pass-through, buffer start, step) and
// pushes it into a 2-entry command queue; a back-end sequencer runs one
// interpolation multiply, one error multiply and one gain multiply per error.
// In the back end an inner sample of a buffer first settles the pending error
// of the previous result (interpolate, sum, error, add, gain, phase), then
// interpolates; the second sample only interpolates, a last one adds its own
// error pass, a pass-through goes straight to output and a buffer start only
// loads history. The result leaves through an output register, so the back
// end runs on while one result waits. A write to sps starts a restoring
// reciprocal (2^20 / sps); intake pauses meanwhile. Reset clears phase,
// history and queue; sps resets to 10. A stalled receiver fills the output
// register, then the queue, then drops samples.ready; nothing is lost.
module gardner_timing_interpolator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gti_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [gti_pkg::GAIN_BITS-1:0]        cfg_wdata,
	gti_in_if.sink                               samples,
	gti_out_if.source                            results
);
	gti_pkg::cfg_t                  cfg_q;
	logic                           recip_start;
	logic                           recip_busy;
	logic [gti_pkg::PHASE_BITS-1:0] nom;
	logic                           push;
	gti_pkg::cmd_t                  push_cmd;
	logic                           fifo_full;
	logic                           fifo_empty;
	logic                           pop;
	gti_pkg::cmd_t                  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b0;
			cfg_q.sps             <= gti_pkg::SPS_BITS'(gti_pkg::SPS_RESET);
			cfg_q.force_high_rate <= 1'b0;
			cfg_q.gain            <= '0;
		end else if (cfg_we) begin
			unique case (gti_pkg::cfg_idx_t'(cfg_index))
				gti_pkg::CFG_ENABLE: cfg_q.enable          <= cfg_wdata[0];
				gti_pkg::CFG_SPS:    cfg_q.sps             <= cfg_wdata[gti_pkg::SPS_BITS-1:0];
				gti_pkg::CFG_FORCE:  cfg_q.force_high_rate <= cfg_wdata[0];
				gti_pkg::CFG_GAIN:   cfg_q.gain            <= cfg_wdata;
				default:             cfg_q.enable          <= cfg_q.enable;
			endcase
		end
	end

	assign recip_start = cfg_we && (gti_pkg::cfg_idx_t'(cfg_index) == gti_pkg::CFG_SPS);

	gti_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (recip_start),
		.sps    (cfg_q.sps),
		.nom    (nom),
		.busy   (recip_busy)
	);

	gti_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.cfg        (cfg_q),
		.recip_busy (recip_busy),
		.fifo_full  (fifo_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	gti_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.full   (fifo_full),
		.pop    (pop),
		.empty  (fifo_empty),
		.head   (head)
	);

	gti_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.head       (head),
		.pop        (pop),
		.gain       (cfg_q.gain),
		.nom        (nom),
		.results    (results)
	);
endmodule

[rtl/gti_recip.sv]
`timescale 1ns / 1ps
`include "gardner_timing_interpolator_defines.svh"
module gti_recip (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [gti_pkg::SPS_BITS-1:0]        sps,
	output logic [gti_pkg::PHASE_BITS-1:0]      nom,
	output logic                                busy
);
	localparam int CNT_BITS = $clog2(gti_pkg::PHASE_BITS + 1);

	logic                              busy_q;
	logic [CNT_BITS-1:0]               cnt_q;
	logic [gti_pkg::SPS_BITS-1:0]      rem_q;
	logic [gti_pkg::PHASE_BITS-1:0]    quo_q;
	logic [gti_pkg::PHASE_BITS-1:0]    nom_q;
	logic                              dbit;
	logic [gti_pkg::SPS_BITS:0]        trial;
	logic [gti_pkg::SPS_BITS:0]        rem_n;
	logic                              ge;
	logic [gti_pkg::PHASE_BITS-1:0]    quo_n;

	// restoring division of 2^PHASE_BITS by sps, one quotient bit per cycle
	assign dbit  = (cnt_q == CNT_BITS'(gti_pkg::PHASE_BITS));
	assign trial = {rem_q, dbit};
	assign ge    = (trial >= {1'b0, sps});
	assign rem_n = ge ? (trial - {1'b0, sps}) : trial;
	assign quo_n = {quo_q[gti_pkg::PHASE_BITS-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			nom_q  <= gti_pkg::NOM_RESET;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(gti_pkg::PHASE_BITS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				nom_q  <= quo_n;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_n[gti_pkg::SPS_BITS-1:0];
			quo_q <= quo_n;
		end
	end

	assign nom  = nom_q;
	assign busy = busy_q;

	`GTI_ASSERT_NXT(a_start_busy, start, busy_q)
endmodule

[rtl/gti_front.sv]
`timescale 1ns / 1ps
module gti_front (
	input  logic          clk,
	input  logic          arst_n,
	gti_in_if.sink        samples,
	input  gti_pkg::cfg_t cfg,
	input  logic          recip_busy,
	input  logic          fifo_full,
	output logic          push,
	output gti_pkg::cmd_t cmd
);
	typedef enum logic [2:0] {
		POS_NONE = 3'b001,
		POS_ONE  = 3'b010,
		POS_TWO  = 3'b100
	} pos_t;

	pos_t pos_q;
	pos_t pos_d;
	logic bypass;

	assign samples.ready = !fifo_full && !recip_busy;
	assign push          = samples.valid && samples.ready;

	assign bypass = !cfg.enable || (cfg.sps <= gti_pkg::SPS_BITS'(1)) ||
		((cfg.sps > gti_pkg::SPS_BITS'(gti_pkg::MAX_SPS)) && !cfg.force_high_rate);

	always_comb begin
		cmd.kind = gti_pkg::CMD_PASS;
		cmd.x_i  = samples.sample_i;
		cmd.x_q  = samples.sample_q;
		cmd.last = samples.last_of_buffer;
		cmd.pre  = 1'b0;
		pos_d    = pos_q;
		if (bypass) begin
			pos_d = POS_NONE;
		end else if (samples.first_of_buffer || (pos_q == POS_NONE)) begin
			if (samples.last_of_buffer) begin
				pos_d = POS_NONE;
			end else begin
				cmd.kind = gti_pkg::CMD_LOAD;
				pos_d    = POS_ONE;
			end
		end else begin
			// pending error of the previous result is settled before this one
			cmd.kind = gti_pkg::CMD_STEP;
			cmd.pre  = (pos_q == POS_TWO);
			pos_d    = samples.last_of_buffer ? POS_NONE : POS_TWO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_NONE;
		end else if (push) begin
			pos_q <= pos_d;
		end
	end
endmodule

[rtl/gti_fifo.sv]
`timescale 1ns / 1ps
`include "gardner_timing_interpolator_defines.svh"
module gti_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gti_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output gti_pkg::cmd_t head
);
	localparam int PTR_BITS = (gti_pkg::QUEUE_DEPTH > 1) ? $clog2(gti_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(gti_pkg::QUEUE_DEPTH + 1);

	gti_pkg::cmd_t       entry_q [gti_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_q;
	logic [PTR_BITS-1:0] rd_q;
	logic [CNT_BITS-1:0] count_q;

	assign full  = (count_q == CNT_BITS'(gti_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_BITS'(gti_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_BITS'(gti_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= wdata;
		end
	end

	`GTI_ASSERT_IMP(a_no_overflow, push, !full)
	`GTI_ASSERT_IMP(a_no_underflow, pop, !empty)
endmodule

[rtl/gti_back.sv]
`timescale 1ns / 1ps
`include "gardner_timing_interpolator_defines.svh"
module gti_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fifo_empty,
	input  gti_pkg::cmd_t                        head,
	output logic                                 pop,
	input  logic signed [gti_pkg::GAIN_BITS-1:0] gain,
	input  logic [gti_pkg::PHASE_BITS-1:0]       nom,
	gti_out_if.source                            results
);
	localparam int SB = gti_pkg::SAMPLE_BITS;
	localparam int PB = gti_pkg::PHASE_BITS;
	localparam int EB = gti_pkg::ERR_BITS;
	localparam int MB = SB + 1 + PB + 1;
	localparam int GB = gti_pkg::GAIN_BITS + EB;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_INT   = 8'b0000_0010,
		S_SUM   = 8'b0000_0100,
		S_ERR   = 8'b0000_1000,
		S_ADD   = 8'b0001_0000,
		S_GAIN  = 8'b0010_0000,
		S_PHASE = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		PASS_PRE  = 3'b001,
		PASS_MAIN = 3'b010,
		PASS_POST = 3'b100
	} pass_t;

	state_t state_q;
	pass_t  pass_q;
	logic   out_v_q;
	logic   fire;
	logic [PB-1:0] phase_q;

	logic signed [SB-1:0] h0_i_q, h0_q_q, h1_i_q, h1_q_q, h2_i_q, h2_q_q;
	logic signed [SB-1:0] cur_i_q, cur_q_q;
	gti_pkg::cmd_kind_t   cur_kind_q;
	logic                 cur_last_q;
	logic                 cur_pre_q;
	logic signed [SB-1:0] y_i_q, y_q_q;
	logic signed [MB-1:0] mi_q, mq_q;
	logic signed [EB-1:0] ei_q, eq_q, e_q;
	logic [PB-1:0]        corr_q;
	logic signed [SB-1:0] out_i_q, out_q_q;
	logic                 out_last_q;

	logic signed [SB-1:0] a_i, a_q, b_i, b_q, far_i, far_q, dr_i, dr_q;
	logic signed [SB:0]   d_i, d_q;
	logic signed [PB:0]   frac;
	logic signed [MB-1:0] mi, mq;
	logic signed [EB-1:0] ei, eq;
	logic signed [GB-1:0] gp;

	// interpolation operands: pending error uses (k-1, k), current result (k, k+1)
	assign a_i   = (pass_q == PASS_PRE) ? h1_i_q : h2_i_q;
	assign a_q   = (pass_q == PASS_PRE) ? h1_q_q : h2_q_q;
	assign b_i   = (pass_q == PASS_PRE) ? h2_i_q : cur_i_q;
	assign b_q   = (pass_q == PASS_PRE) ? h2_q_q : cur_q_q;
	assign d_i   = {b_i[SB-1], b_i} - {a_i[SB-1], a_i};
	assign d_q   = {b_q[SB-1], b_q} - {a_q[SB-1], a_q};
	assign frac  = {1'b0, phase_q};
	assign mi    = d_i * frac;
	assign mq    = d_q * frac;

	assign far_i = (pass_q == PASS_PRE) ? h0_i_q : h1_i_q;
	assign far_q = (pass_q == PASS_PRE) ? h0_q_q : h1_q_q;
	assign dr_i  = cur_i_q - far_i;
	assign dr_q  = cur_q_q - far_q;
	assign ei    = dr_i * y_i_q;
	assign eq    = dr_q * y_q_q;
	assign gp    = gain * e_q;

	assign pop  = (state_q == S_IDLE) && !fifo_empty;
	assign fire = (state_q == S_OUT) && (!out_v_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= PASS_MAIN;
			out_v_q <= 1'b0;
			phase_q <= '0;
			h0_i_q  <= '0;
			h0_q_q  <= '0;
			h1_i_q  <= '0;
			h1_q_q  <= '0;
			h2_i_q  <= '0;
			h2_q_q  <= '0;
		end else begin
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (head.kind)
							gti_pkg::CMD_PASS: state_q <= S_OUT;
							gti_pkg::CMD_LOAD: begin
								h0_i_q <= head.x_i;
								h0_q_q <= head.x_q;
								h1_i_q <= head.x_i;
								h1_q_q <= head.x_q;
								h2_i_q <= head.x_i;
								h2_q_q <= head.x_q;
							end
							gti_pkg::CMD_STEP: begin
								pass_q  <= head.pre ? PASS_PRE : PASS_MAIN;
								state_q <= S_INT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_INT: state_q <= S_SUM;
				S_SUM: begin
					if (pass_q == PASS_PRE) begin
						state_q <= S_ERR;
					end else if (cur_last_q) begin
						pass_q  <= PASS_POST;
						state_q <= S_ERR;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_ERR:  state_q <= S_ADD;
				S_ADD:  state_q <= S_GAIN;
				S_GAIN: state_q <= S_PHASE;
				S_PHASE: begin
					phase_q <= phase_q + nom + corr_q;
					if (pass_q == PASS_PRE) begin
						pass_q  <= PASS_MAIN;
						state_q <= S_INT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (fire) begin
						if (cur_kind_q == gti_pkg::CMD_STEP) begin
							h0_i_q <= h1_i_q;
							h0_q_q <= h1_q_q;
							h1_i_q <= h2_i_q;
							h1_q_q <= h2_q_q;
							h2_i_q <= cur_i_q;
							h2_q_q <= cur_q_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_kind_q <= head.kind;
			cur_i_q    <= head.x_i;
			cur_q_q    <= head.x_q;
			cur_last_q <= head.last;
			cur_pre_q  <= head.pre;
			y_i_q      <= head.x_i;
			y_q_q      <= head.x_q;
		end
		if (state_q == S_INT) begin
			mi_q <= mi;
			mq_q <= mq;
		end
		if (state_q == S_SUM) begin
			y_i_q <= a_i + mi_q[PB+SB-1:PB];
			y_q_q <= a_q + mq_q[PB+SB-1:PB];
		end
		if (state_q == S_ERR) begin
			ei_q <= ei;
			eq_q <= eq;
		end
		if (state_q == S_ADD) begin
			e_q <= ei_q + eq_q;
		end
		if (state_q == S_GAIN) begin
			corr_q <= gp[gti_pkg::CORR_SHIFT+PB-1:gti_pkg::CORR_SHIFT];
		end
		if (fire) begin
			out_i_q    <= y_i_q;
			out_q_q    <= y_q_q;
			out_last_q <= cur_last_q;
		end
	end

	assign results.valid    = out_v_q;
	assign results.out_i    = out_i_q;
	assign results.out_q    = out_q_q;
	assign results.out_last = out_last_q;

	`GTI_ASSERT_IMP(a_pre_needs_flag, (state_q != S_IDLE) && (pass_q == PASS_PRE), cur_pre_q)
	`GTI_ASSERT_NXT(a_step_starts, pop && (head.kind == gti_pkg::CMD_STEP), state_q == S_INT)
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
	import gti_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int RESET_LEN   = 5;
	localparam int LIMIT       = 400000;
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 104;
	localparam int HOLD_AT     = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int CALM_AT     = 1150;
	localparam int MAX_SHOWN   = 10;

	localparam logic signed [SAMPLE_BITS-1:0] SMAX = 16'sh7fff;
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = 16'sh8000;
	localparam logic signed [SAMPLE_BITS-1:0] S0   = 16'sd0;
	localparam logic [GAIN_BITS-1:0] GMAX = 22'h100000;
	localparam logic [GAIN_BITS-1:0] GMIN = 22'h300000;
	localparam logic [GAIN_BITS-1:0] V0   = 22'd0;
	localparam logic [GAIN_BITS-1:0] V1   = 22'd1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] i;
		logic signed [SAMPLE_BITS-1:0] q;
	} iq_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] i;
		logic signed [SAMPLE_BITS-1:0] q;
		logic                          last;
	} result_t;

	typedef enum logic [1:0] {BUF_CLOSED, BUF_ONE, BUF_OPEN} fill_t;
	typedef enum logic [1:0] {ROW_REG, ROW_STEP, ROW_KNOWN} row_kind_t;

	typedef struct packed {
		row_kind_t                     kind;
		cfg_idx_t                      idx;
		logic [GAIN_BITS-1:0]          val;
		logic signed [SAMPLE_BITS-1:0] xi;
		logic signed [SAMPLE_BITS-1:0] xq;
		logic                          first;
		logic                          last;
		logic signed [SAMPLE_BITS-1:0] wi;
		logic signed [SAMPLE_BITS-1:0] wq;
		logic                          wl;
	} row_t;

	localparam int NROWS = 38;
	localparam row_t PLAN [NROWS] = '{
		'{ROW_KNOWN, CFG_ENABLE, V0, SMAX, SMIN, 1'b1, 1'b1, SMAX, SMIN, 1'b1},
		'{ROW_REG, CFG_ENABLE, V1, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_KNOWN, CFG_ENABLE, V0, 16'sd1234, -16'sd5, 1'b1, 1'b1,
			16'sd1234, -16'sd5, 1'b1},
		'{ROW_STEP, CFG_ENABLE, V0, 16'sd100, 16'sd200, 1'b1, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, SMAX, SMIN, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, 16'sd5, -16'sd5, 1'b0, 1'b1, S0, S0, 1'b0},
		// no first mark: opens a buffer
		'{ROW_STEP, CFG_ENABLE, V0, 16'sd7, 16'sd8, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, 16'sd9, 16'sd10, 1'b0, 1'b1, S0, S0, 1'b0},
		// first mark inside an open buffer
		'{ROW_STEP, CFG_ENABLE, V0, 16'sd1, 16'sd1, 1'b1, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, 16'sd3, 16'sd3, 1'b1, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, 16'sd4, 16'sd4, 1'b0, 1'b1, S0, S0, 1'b0},
		'{ROW_REG, CFG_GAIN, GMAX, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, SMIN, SMIN, 1'b1, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, SMAX, SMAX, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, SMIN, SMIN, 1'b0, 1'b1, S0, S0, 1'b0},
		'{ROW_REG, CFG_GAIN, GMIN, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, SMAX, SMIN, 1'b1, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, SMIN, SMAX, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, SMAX, SMIN, 1'b0, 1'b1, S0, S0, 1'b0},
		'{ROW_REG, CFG_SPS, 22'd13, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_KNOWN, CFG_ENABLE, V0, 16'sd11, 16'sd22, 1'b1, 1'b0,
			16'sd11, 16'sd22, 1'b0},
		'{ROW_REG, CFG_FORCE, V1, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, 16'sd100, -16'sd100, 1'b1, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, -16'sd300, 16'sd300, 1'b0, 1'b1, S0, S0, 1'b0},
		'{ROW_REG, CFG_SPS, 22'd255, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, 16'sd1000, 16'sd2000, 1'b1, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, -16'sd1000, -16'sd2000, 1'b0, 1'b0, S0, S0, 1'b0},
		// disable drops the open buffer
		'{ROW_REG, CFG_ENABLE, V0, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_KNOWN, CFG_ENABLE, V0, 16'sd55, 16'sd66, 1'b0, 1'b1,
			16'sd55, 16'sd66, 1'b1},
		'{ROW_REG, CFG_ENABLE, V1, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_REG, CFG_SPS, V1, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_KNOWN, CFG_ENABLE, V0, 16'sd77, 16'sd88, 1'b1, 1'b0,
			16'sd77, 16'sd88, 1'b0},
		'{ROW_REG, CFG_SPS, V0, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_KNOWN, CFG_ENABLE, V0, 16'sd99, -16'sd99, 1'b0, 1'b0,
			16'sd99, -16'sd99, 1'b0},
		'{ROW_REG, CFG_SPS, 22'd2, S0, S0, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, SMIN, SMAX, 1'b1, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, SMAX, SMIN, 1'b0, 1'b0, S0, S0, 1'b0},
		'{ROW_STEP, CFG_ENABLE, V0, -16'sd1, -16'sd1, 1'b0, 1'b1, S0, S0, 1'b0}
	};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [GAIN_BITS-1:0]    cfg_wdata;

	gti_in_if  samples();
	gti_out_if results();

	gardner_timing_interpolator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.results   (results)
	);

	// block model state, as after reset
	logic                        en_cfg    = 1'b0;
	logic [SPS_BITS-1:0]         sps_cfg   = SPS_BITS'(SPS_RESET);
	logic                        force_cfg = 1'b0;
	logic signed [GAIN_BITS-1:0] gain_cfg  = '0;
	logic [PHASE_BITS-1:0]       phase_acc = '0;
	iq_t                         hist [3]  = '{default: '0};
	fill_t                       fill      = BUF_CLOSED;

	result_t due_outputs [$];
	int      sent   = 0;
	int      faults = 0;
	int      cycles = 0;
	bit      calm   = 1'b0;

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("gardner_timing_interpolator regression: fail");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] lerp(
			input logic signed [SAMPLE_BITS-1:0] a, input logic signed [SAMPLE_BITS-1:0] b);
		longint w;
		w = ((longint'(1) <<< PHASE_BITS) - longint'(phase_acc)) * longint'(a)
			+ longint'(phase_acc) * longint'(b);
		return SAMPLE_BITS'(w >>> PHASE_BITS);
	endfunction

	function automatic void nudge_phase(iq_t y, iq_t far, iq_t near);
		logic signed [SAMPLE_BITS-1:0] di;
		logic signed [SAMPLE_BITS-1:0] dq;
		logic signed [ERR_BITS-1:0]    err;
		longint                        prod;
		di = near.i - far.i;
		dq = near.q - far.q;
		err = ERR_BITS'(longint'(di) * longint'($signed(y.i))
			+ longint'(dq) * longint'($signed(y.q)));
		prod = longint'(gain_cfg) * longint'(err);
		phase_acc = phase_acc + PHASE_BITS'((longint'(1) <<< PHASE_BITS) / longint'(sps_cfg))
			+ PHASE_BITS'(prod >>> CORR_SHIFT);
	endfunction

	function automatic bit interpolate_step(iq_t x, logic first, logic last,
			output result_t r);
		iq_t mid;
		iq_t y;
		r = '0;
		if (!en_cfg || sps_cfg <= 1 || (sps_cfg > MAX_SPS && !force_cfg)) begin
			fill = BUF_CLOSED;
			r = '{x.i, x.q, last};
			return 1'b1;
		end
		if (first || fill == BUF_CLOSED) begin
			if (last) begin
				fill = BUF_CLOSED;
				r = '{x.i, x.q, 1'b1};
				return 1'b1;
			end
			hist[0] = x;
			hist[1] = x;
			hist[2] = x;
			fill = BUF_ONE;
			return 1'b0;
		end
		// error of the previous point needs this sample
		if (fill == BUF_OPEN) begin
			mid.i = lerp(hist[1].i, hist[2].i);
			mid.q = lerp(hist[1].q, hist[2].q);
			nudge_phase(mid, hist[0], x);
		end
		y.i = lerp(hist[2].i, x.i);
		y.q = lerp(hist[2].q, x.q);
		r = '{y.i, y.q, last};
		if (last) begin
			nudge_phase(y, hist[1], x);
			fill = BUF_CLOSED;
		end else begin
			fill = BUF_OPEN;
		end
		hist[0] = hist[1];
		hist[1] = hist[2];
		hist[2] = x;
		return 1'b1;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] any_value();
		case ($urandom_range(0, 9))
			0: return SMAX;
			1: return SMIN;
			2: return S0;
			3: return SAMPLE_BITS'(int'($urandom_range(0, 255)) - 128);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic sender_idle(int n);
		repeat (n) begin
			@(negedge clk);
			samples.valid = 1'b0;
			samples.sample_i = SAMPLE_BITS'($urandom);
			samples.sample_q = SAMPLE_BITS'($urandom);
			samples.first_of_buffer = 1'($urandom);
			samples.last_of_buffer = 1'($urandom);
		end
	endtask

	task automatic send_item(iq_t x, logic first, logic last, bit known, result_t want,
			int gap_rate);
		result_t r;
		bit      got;
		if (!calm && gap_rate != 0 && $urandom_range(1, gap_rate) == 1)
			sender_idle($urandom_range(1, 12));
		@(negedge clk);
		samples.valid = 1'b1;
		samples.sample_i = x.i;
		samples.sample_q = x.q;
		samples.first_of_buffer = first;
		samples.last_of_buffer = last;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		got = interpolate_step(x, first, last, r);
		if (known)
			due_outputs.push_back(want);
		else if (got)
			due_outputs.push_back(r);
		sent++;
		calm = (sent >= CALM_AT);
	endtask

	// sender stops until every result is out, then the back end gets time to finish
	task automatic settle();
		sender_idle(1);
		while (due_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [GAIN_BITS-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_ENABLE: en_cfg = val[0];
			CFG_SPS:    sps_cfg = val[SPS_BITS-1:0];
			CFG_FORCE:  force_cfg = val[0];
			CFG_GAIN:   gain_cfg = signed'(val);
		endcase
	endtask

	initial begin : receiver
		int hold_left;
		int stall_left;
		bit held;
		hold_left = 0;
		stall_left = 0;
		held = 1'b0;
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				results.ready = 1'b0;
			end else if (!held && sent >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				results.ready = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				results.ready = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 11);
				results.ready = 1'b0;
			end else begin
				results.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n && results.valid && results.ready) begin
			if (due_outputs.size() == 0) begin
				faults++;
				if (faults <= MAX_SHOWN)
					$display("unexpected result: i=%0d q=%0d last=%0b",
						results.out_i, results.out_q, results.out_last);
			end else begin
				want = due_outputs.pop_front();
				if (results.out_i !== want.i || results.out_q !== want.q ||
						results.out_last !== want.last) begin
					faults++;
					if (faults <= MAX_SHOWN)
						$display("mismatch: want i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
							want.i, want.q, want.last,
							results.out_i, results.out_q, results.out_last);
				end
			end
		end
	end

	initial begin : stimulus
		iq_t                         x;
		int                          len;
		int                          target;
		int                          gap_rate;
		logic                        en;
		logic                        frc;
		logic [SPS_BITS-1:0]         sps;
		logic signed [GAIN_BITS-1:0] g;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENABLE;
		cfg_wdata = '0;
		samples.valid = 1'b0;
		samples.sample_i = '0;
		samples.sample_q = '0;
		samples.first_of_buffer = 1'b0;
		samples.last_of_buffer = 1'b0;
		repeat (RESET_LEN) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int n = 0; n < NROWS; n++) begin
			if (PLAN[n].kind == ROW_REG) begin
				settle();
				write_reg(PLAN[n].idx, PLAN[n].val);
			end else begin
				x = '{PLAN[n].xi, PLAN[n].xq};
				send_item(x, PLAN[n].first, PLAN[n].last, PLAN[n].kind == ROW_KNOWN,
					'{PLAN[n].wi, PLAN[n].wq, PLAN[n].wl}, 2);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					en = 1'b1; sps = 8'd2; frc = 1'b0; g = GMAX;
				end
				1: begin
					en = 1'b1; sps = 8'd12; frc = 1'b0; g = GMIN;
				end
				default: begin
					en = ($urandom_range(0, 9) != 0);
					case ($urandom_range(0, 7))
						0: sps = SPS_BITS'($urandom_range(0, 1));
						1: sps = SPS_BITS'($urandom_range(13, 255));
						default: sps = SPS_BITS'($urandom_range(2, 12));
					endcase
					frc = 1'($urandom);
					case ($urandom_range(0, 4))
						0: g = GMAX;
						1: g = GMIN;
						2: g = '0;
						3: g = GAIN_BITS'(int'($urandom_range(0, 8192)) - 4096);
						default: g = GAIN_BITS'(int'($urandom_range(0, 2097152)) - 1048576);
					endcase
				end
			endcase
			settle();
			write_reg(CFG_ENABLE, GAIN_BITS'(en));
			write_reg(CFG_FORCE, GAIN_BITS'(frc));
			write_reg(CFG_GAIN, g);
			write_reg(CFG_SPS, GAIN_BITS'(sps));
			case ($urandom_range(0, 3))
				0: gap_rate = 0;
				1: gap_rate = 2;
				2: gap_rate = 4;
				default: gap_rate = 8;
			endcase
			target = sent + PHASE_ITEMS;
			while (sent < target) begin
				if ($urandom_range(0, 6) != 0) begin
					len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
					for (int k = 0; k < len; k++) begin
						x = '{any_value(), any_value()};
						send_item(x, k == 0, k == len - 1, 1'b0, '0, gap_rate);
					end
				end else begin
					x = '{any_value(), any_value()};
					send_item(x, 1'($urandom), 1'($urandom), 1'b0, '0, gap_rate);
				end
			end
		end

		sender_idle(1);
		while (due_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (faults == 0 && due_outputs.size() == 0) begin
			$display("gardner_timing_interpolator regression: pass");
		end else begin
			$display("gardner_timing_interpolator regression: fail");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/gti_pkg.sv
rtl/gti_if.sv
rtl/gti_recip.sv
rtl/gti_front.sv
rtl/gti_fifo.sv
rtl/gti_back.sv
rtl/gardner_timing_interpolator.sv
test/tb.sv
